[rtl/core/aais_pkg.sv]
// Shared types, constants and register codes for the area-average shrink block.
`default_nettype none
package aais_pkg;
  localparam int MaxWidth   = 4096;
  localparam int SampleBits = 16;
  localparam int SumBits    = 32;
  localparam int RowBits    = SumBits + 12;
  localparam int ColBits    = 12;

  typedef enum logic [2:0] {
    REG_SRC_W   = 3'd0,
    REG_SRC_H   = 3'd1,
    REG_RES_W   = 3'd2,
    REG_RES_H   = 3'd3,
    REG_STEP    = 3'd4,
    REG_GAIN    = 3'd5,
    REG_COLOUR  = 3'd6,
    REG_SWAP    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] sample_a;
    logic [15:0] sample_b;
    logic [15:0] sample_c;
    logic        frame_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [10:0] out_column;
    logic [10:0] out_row;
    logic        row_last;
    logic        frame_last;
  } out_word_t;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic [SumBits-1:0] sa;
    logic [SumBits-1:0] sb;
    logic [SumBits-1:0] sc;
    logic [ColBits-1:0] col;
    logic               wr_col;
    logic               first_row;
    logic               do_row;
    logic               first_col;
    logic               emit;
    logic [12:0]        cx;
    logic [12:0]        cy;
    logic [10:0]        rcol;
    logic [10:0]        rrow;
    logic               rlast;
    logic               flast;
  } task_t;

  typedef struct packed {
    logic [12:0] src_w;
    logic [12:0] src_h;
    logic [11:0] res_w;
    logic [11:0] res_h;
    logic [15:0] step;
    logic [23:0] gain;
    logic        colour;
    logic        swap;
  } cfg_t;
endpackage
`default_nettype wire

[rtl/core/aais_front.sv]
// Front part: scales samples, tracks source and band positions, classifies each pixel.
`default_nettype none
module aais_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire aais_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire aais_pkg::in_word_t in_data,
  output logic                  t_valid,
  input  wire logic             t_ready,
  output aais_pkg::task_t       t_data
);
  import aais_pkg::*;

  // stage 1: scaled samples plus raw fields; stage 2: classification
  logic        s1_v_r;
  logic [SumBits-1:0] s1_a_r, s1_b_r, s1_c_r;
  logic        s1_fs_r;
  logic        t_v_r;
  task_t       t_r;

  logic [11:0] scol_r, srow_r;
  logic [10:0] rcol_r, rrow_r;
  logic [12:0] rbs_r, rbe_r, cbs_r, cbe_r;

  logic [39:0] pa, pb, pc;
  logic        adv;

  assign t_valid  = t_v_r;
  assign t_data   = t_r;
  assign adv      = !t_v_r || t_ready;
  assign in_ready = !s1_v_r || adv;

  assign pa = 40'(in_data.sample_a) * 40'(cfg.gain) + 40'h8000;
  assign pb = 40'(in_data.sample_b) * 40'(cfg.gain) + 40'h8000;
  assign pc = 40'(in_data.sample_c) * 40'(cfg.gain) + 40'h8000;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (in_ready) s1_v_r <= in_valid;
    if (in_ready && in_valid) begin
      s1_a_r  <= SumBits'(pa[39:16]);
      s1_b_r  <= SumBits'(pb[39:16]);
      s1_c_r  <= SumBits'(pc[39:16]);
      s1_fs_r <= in_data.frame_start;
    end
  end

  // band bounds: floor(i*step/256), saturating; end clamped
  function automatic logic [12:0] bfirst(input logic [11:0] i, input logic [15:0] st);
    logic [27:0] p;
    p = 28'(i) * 28'(st);
    return (p[27:21] != '0) ? 13'h1fff : p[20:8];
  endfunction

  function automatic logic [12:0] clampsz(input logic [12:0] v, input logic lo1,
                                         input logic [12:0] hi);
    logic [12:0] r;
    r = v;
    if (lo1 && r == '0) r = 13'd1;
    if (r > hi) r = hi;
    return r;
  endfunction

  logic [12:0] w, h, rw, rh;
  logic [11:0] scol, srow;
  logic [10:0] rcol, rrow;
  logic [12:0] rbs, rbe, cbs, cbe;
  logic        in_rows, last_row, in_cols, emit;
  logic [11:0] rcol_p1, rrow_p1;
  logic [12:0] nfc, nfr;
  logic        rlast, flast;
  logic [11:0] rrn;
  logic [11:0] scol_n, srow_n;
  logic [10:0] rcol_n, rrow_n;
  logic [12:0] cbs_n, cbe_n, rbs_n, rbe_n;
  logic [12:0] b0, e0;

  always_comb begin
    w  = clampsz(cfg.src_w, 1'b1, 13'd4096);
    h  = clampsz(cfg.src_h, 1'b1, 13'd4096);
    rw = clampsz({1'b0, cfg.res_w}, 1'b0, 13'd2048);
    rh = clampsz({1'b0, cfg.res_h}, 1'b0, 13'd2048);
    b0 = 13'd0;
    e0 = bfirst(12'd1, cfg.step);
    if (s1_fs_r) begin
      scol = '0; srow = '0; rcol = '0; rrow = '0;
      rbs = b0; rbe = (e0 > h) ? h : e0;
      cbs = b0; cbe = (e0 > w) ? w : e0;
    end else begin
      scol = scol_r; srow = srow_r; rcol = rcol_r; rrow = rrow_r;
      rbs = rbs_r; rbe = rbe_r; cbs = cbs_r; cbe = cbe_r;
    end
    in_rows  = ({2'b0, rrow} < rh) && (rbs <= {1'b0, srow}) && ({1'b0, srow} < rbe);
    last_row = in_rows && ({1'b0, srow} + 13'd1 == rbe);
    in_cols  = last_row && ({2'b0, rcol} < rw) && (cbs <= {1'b0, scol}) &&
               ({1'b0, scol} < cbe);
    emit     = in_cols && ({1'b0, scol} + 13'd1 == cbe);
    rcol_p1  = {1'b0, rcol} + 12'd1;
    rrow_p1  = {1'b0, rrow} + 12'd1;
    nfc      = bfirst(rcol_p1, cfg.step);
    nfr      = bfirst(rrow_p1, cfg.step);
    rlast    = ({1'b0, rcol_p1} >= rw) || (nfc >= w);
    flast    = rlast && (({1'b0, rrow_p1} >= rh) || (nfr >= h));

    scol_n = scol + 12'd1; srow_n = srow; rcol_n = rcol; rrow_n = rrow;
    cbs_n = cbs; cbe_n = cbe; rbs_n = rbs; rbe_n = rbe;
    if (emit) begin
      rcol_n = rcol_p1[10:0];
      cbs_n  = nfc;
      cbe_n  = bfirst(rcol_p1 + 12'd1, cfg.step);
      if (cbe_n > w) cbe_n = w;
    end
    rrn = rrow_p1;
    if ({1'b0, scol} + 13'd1 >= w) begin
      scol_n = '0; rcol_n = '0; cbs_n = b0; cbe_n = (e0 > w) ? w : e0;
      if ({1'b0, srow} + 13'd1 >= h) begin
        srow_n = '0; rrow_n = '0; rbs_n = b0; rbe_n = (e0 > h) ? h : e0;
      end else begin
        srow_n = srow + 12'd1;
        if (last_row) begin
          rrow_n = rrn[10:0];
          rbs_n  = nfr;
          rbe_n  = bfirst(rrn + 12'd1, cfg.step);
          if (rbe_n > h) rbe_n = h;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
      scol_r <= '0; srow_r <= '0; rcol_r <= '0; rrow_r <= '0;
      rbs_r <= '0; cbs_r <= '0;
      rbe_r <= 13'd2; cbe_r <= 13'd2;
    end else if (adv) begin
      t_v_r <= s1_v_r;
      if (s1_v_r) begin
        scol_r <= scol_n; srow_r <= srow_n; rcol_r <= rcol_n; rrow_r <= rrow_n;
        rbs_r <= rbs_n; rbe_r <= rbe_n; cbs_r <= cbs_n; cbe_r <= cbe_n;
      end
    end
    if (adv && s1_v_r) begin
      t_r.sa        <= s1_a_r;
      t_r.sb        <= s1_b_r;
      t_r.sc        <= s1_c_r;
      t_r.col       <= scol;
      t_r.wr_col    <= in_rows;
      t_r.first_row <= ({1'b0, srow} == rbs);
      t_r.do_row    <= in_cols;
      t_r.first_col <= ({1'b0, scol} == cbs);
      t_r.emit      <= emit;
      t_r.cx        <= cbe - cbs;
      t_r.cy        <= rbe - rbs;
      t_r.rcol      <= rcol;
      t_r.rrow      <= rrow;
      t_r.rlast     <= rlast;
      t_r.flast     <= flast;
    end
  end
endmodule
`default_nettype wire

[rtl/core/aais_queue.sv]
// Two-entry queue between the front and back parts.
`default_nettype none
module aais_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            w_valid,
  output logic                 w_ready,
  input  wire aais_pkg::task_t w_data,
  output logic                 r_valid,
  input  wire logic            r_ready,
  output aais_pkg::task_t      r_data
);
  import aais_pkg::*;

  task_t    mem_r [2];
  logic     wp_r, rp_r;
  logic [1:0] cnt_r;
  logic     wr, rd;

  assign w_ready = cnt_r != 2'd2;
  assign r_valid = cnt_r != 2'd0;
  assign r_data  = mem_r[rp_r];
  assign wr = w_valid && w_ready;
  assign rd = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem_r[wp_r] <= w_data;
  end
endmodule
`default_nettype wire

[rtl/core/aais_div.sv]
// Iterative restoring divider for the three channel averages, then clamp and byte ordering.
`default_nettype none
module aais_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire aais_pkg::cfg_t           cfg,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [aais_pkg::RowBits-1:0] sum_a,
  input  wire logic [aais_pkg::RowBits-1:0] sum_b,
  input  wire logic [aais_pkg::RowBits-1:0] sum_c,
  input  wire logic [12:0]              cx,
  input  wire logic [12:0]              cy,
  input  wire logic [10:0]              rcol,
  input  wire logic [10:0]              rrow,
  input  wire logic                     rlast,
  input  wire logic                     flast,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output aais_pkg::out_word_t           out_data
);
  import aais_pkg::*;

  typedef enum logic [1:0] {IDLE, PASS1, PASS2, DONE} st_t;
  st_t st_r;
  logic [5:0] bit_r;
  logic [RowBits-1:0] q_r [3];
  logic [RowBits-1:0] rem_r [3];
  logic [12:0] dv_r, cy_r;
  logic [10:0] rcol_r, rrow_r;
  logic rlast_r, flast_r;
  logic ov_r;
  out_word_t od_r;

  logic [RowBits:0] tr [3];
  logic [7:0] v [3];
  logic [7:0] b0, b1, b2;

  assign busy      = st_r != IDLE || ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tr[k] = {rem_r[k], q_r[k][bit_r]} - {{(RowBits-12){1'b0}}, dv_r};
      v[k]  = (q_r[k] > RowBits'(255)) ? 8'hff : q_r[k][7:0];
    end
    b1 = cfg.colour ? v[1] : v[0];
    b2 = cfg.colour ? v[2] : v[0];
    b0 = cfg.swap ? b2 : v[0];
    b2 = cfg.swap ? v[0] : b2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= IDLE; ov_r <= 1'b0; bit_r <= '0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        IDLE: if (start) begin
          q_r[0] <= sum_a; q_r[1] <= sum_b; q_r[2] <= sum_c;
          for (int k = 0; k < 3; k++) rem_r[k] <= '0;
          dv_r <= cx; cy_r <= cy;
          rcol_r <= rcol; rrow_r <= rrow; rlast_r <= rlast; flast_r <= flast;
          bit_r <= 6'(RowBits - 1);
          st_r <= PASS1;
        end
        PASS1, PASS2: begin
          // one quotient bit per cycle, dividend shifted in place
          for (int k = 0; k < 3; k++) begin
            if (st_r == PASS1 && bit_r == '0) rem_r[k] <= '0;
            else if (!tr[k][RowBits]) rem_r[k] <= tr[k][RowBits-1:0];
            else rem_r[k] <= {rem_r[k][RowBits-2:0], q_r[k][bit_r]};
            q_r[k][bit_r] <= !tr[k][RowBits];
          end
          if (bit_r == '0) begin
            if (st_r == PASS1) begin
              dv_r <= cy_r;
              bit_r <= 6'(RowBits - 1);
              st_r <= PASS2;
            end else st_r <= DONE;
          end else bit_r <= bit_r - 6'd1;
        end
        DONE: if (!ov_r) begin
          ov_r <= 1'b1;
          od_r <= '{out_byte0: b0, out_byte1: b1, out_byte2: b2,
                    out_column: rcol_r, out_row: rrow_r,
                    row_last: rlast_r, frame_last: flast_r};
          st_r <= IDLE;
        end
        default: st_r <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/aais_back.sv]
// Back part: column sum memories, horizontal band sum, and the averaging divider.
`default_nettype none
module aais_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire aais_pkg::cfg_t  cfg,
  input  wire logic            t_valid,
  output logic                 t_ready,
  input  wire aais_pkg::task_t t_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output aais_pkg::out_word_t  out_data
);
  import aais_pkg::*;

  logic [SumBits-1:0] mem_a [MaxWidth];
  logic [SumBits-1:0] mem_b [MaxWidth];
  logic [SumBits-1:0] mem_c [MaxWidth];

  // stage 1 reads memory; stage 2 updates column and row sums
  logic  v1_r;
  task_t t1_r;
  logic [SumBits-1:0] rd_a_r, rd_b_r, rd_c_r;
  logic [RowBits-1:0] rs_a_r, rs_b_r, rs_c_r;
  logic [SumBits-1:0] na, nb, nc;
  logic [RowBits-1:0] ra, rb, rc;
  logic div_busy, go;

  // forward a write to the same column that is just behind (one-pixel-wide source)
  assign t_ready = !v1_r || !div_busy;
  assign go      = v1_r && !div_busy;

  always_comb begin
    if (t1_r.first_row) begin
      na = t1_r.sa; nb = t1_r.sb; nc = t1_r.sc;
    end else begin
      na = rd_a_r + t1_r.sa; nb = rd_b_r + t1_r.sb; nc = rd_c_r + t1_r.sc;
    end
    if (t1_r.first_col) begin
      ra = RowBits'(na); rb = RowBits'(nb); rc = RowBits'(nc);
    end else begin
      ra = rs_a_r + RowBits'(na); rb = rs_b_r + RowBits'(nb); rc = rs_c_r + RowBits'(nc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      rs_a_r <= '0; rs_b_r <= '0; rs_c_r <= '0;
    end else begin
      if (t_ready) v1_r <= t_valid;
      if (go && t1_r.do_row) begin
        rs_a_r <= ra; rs_b_r <= rb; rs_c_r <= rc;
      end
    end
    if (t_ready && t_valid) begin
      t1_r   <= t_data;
      if (go && t1_r.wr_col && t1_r.col == t_data.col) begin
        rd_a_r <= na;
        rd_b_r <= nb;
        rd_c_r <= nc;
      end else begin
        rd_a_r <= mem_a[t_data.col];
        rd_b_r <= mem_b[t_data.col];
        rd_c_r <= mem_c[t_data.col];
      end
    end
    if (go && t1_r.wr_col) begin
      mem_a[t1_r.col] <= na;
      mem_b[t1_r.col] <= nb;
      mem_c[t1_r.col] <= nc;
    end
  end

  aais_div u_div (
    .clk, .rst_n, .cfg,
    .start(go && t1_r.emit),
    .busy(div_busy),
    .sum_a(ra), .sum_b(rb), .sum_c(rc),
    .cx(t1_r.cx), .cy(t1_r.cy),
    .rcol(t1_r.rcol), .rrow(t1_r.rrow),
    .rlast(t1_r.rlast), .flast(t1_r.flast),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

[rtl/core/area_average_image_shrink_top.sv]
// Top level: register file, front part, queue and back part.
// Pixels without a result pass at one per cycle while the divider is not busy.
// A result pixel holds the back part while the serial divider runs both of its passes,
// which sets throughput at band ends; the two-entry queue buffers front-part work meanwhile.
// Synchronous active-low reset clears positions, sums and registers to defaults;
// column memories are not cleared; a stored column sum is only used after it is written.
`default_nettype none
module area_average_image_shrink_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire aais_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output aais_pkg::out_word_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import aais_pkg::*;

  cfg_t cfg_r;
  reg_idx_t idx;
  logic f_v, f_r, q_v, q_r;
  task_t f_d, q_d;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{src_w: 13'd640, src_h: 13'd480, res_w: 12'd320, res_h: 12'd240,
                 step: 16'd512, gain: 24'd65536, colour: 1'b1, swap: 1'b0};
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_SRC_W:  cfg_r.src_w  <= pwdata[12:0];
        REG_SRC_H:  cfg_r.src_h  <= pwdata[12:0];
        REG_RES_W:  cfg_r.res_w  <= pwdata[11:0];
        REG_RES_H:  cfg_r.res_h  <= pwdata[11:0];
        REG_STEP:   cfg_r.step   <= pwdata[15:0];
        REG_GAIN:   cfg_r.gain   <= pwdata[23:0];
        REG_COLOUR: cfg_r.colour <= pwdata[0];
        REG_SWAP:   cfg_r.swap   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_W:  prdata = 32'(cfg_r.src_w);
      REG_SRC_H:  prdata = 32'(cfg_r.src_h);
      REG_RES_W:  prdata = 32'(cfg_r.res_w);
      REG_RES_H:  prdata = 32'(cfg_r.res_h);
      REG_STEP:   prdata = 32'(cfg_r.step);
      REG_GAIN:   prdata = 32'(cfg_r.gain);
      REG_COLOUR: prdata = 32'(cfg_r.colour);
      REG_SWAP:   prdata = 32'(cfg_r.swap);
      default:    prdata = '0;
    endcase
  end

  aais_front u_front (.clk, .rst_n, .cfg(cfg_r), .in_valid, .in_ready, .in_data,
                      .t_valid(f_v), .t_ready(f_r), .t_data(f_d));
  aais_queue u_queue (.clk, .rst_n, .w_valid(f_v), .w_ready(f_r), .w_data(f_d),
                      .r_valid(q_v), .r_ready(q_r), .r_data(q_d));
  aais_back  u_back  (.clk, .rst_n, .cfg(cfg_r), .t_valid(q_v), .t_ready(q_r), .t_data(q_d),
                      .out_valid, .out_ready, .out_data);

  a_frame_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.frame_last || out_data.row_last))
    else $error("frame_last without row_last");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule
`default_nettype wire

[dv/area_average_image_shrink_top_tb.sv]
// Testbench for the area-average shrink block: random and extreme-value pixel streams checked against a predictor.
`default_nettype none
module area_average_image_shrink_top_tb;
  import aais_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  area_average_image_shrink_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  in_word_t  pixel_queue[$];
  out_word_t shrunk_queue[$];
  int        errors = 0;
  int        cycles = 0;
  bit        gaps_on = 1'b1;
  int        in_gap = 0;
  int        out_gap = 0;

  // predictor copy of the registers
  int unsigned src_w = 640, src_h = 480, res_w = 320, res_h = 240, step_q = 512;
  longint unsigned gain_q = 65536;
  bit colour_q = 1'b1, swap_q = 1'b0;

  // predictor copy of the datapath state
  bit [31:0] col_sum_a[MaxWidth];
  bit [31:0] col_sum_b[MaxWidth];
  bit [31:0] col_sum_c[MaxWidth];
  int unsigned src_col, src_row, res_col, res_row;
  int unsigned rband_lo, rband_hi, cband_lo, cband_hi;
  bit [43:0] row_sum_a, row_sum_b, row_sum_c;

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned band_lo(int unsigned i);
    return int'((longint'(i) * step_q) >> 8);
  endfunction

  function automatic int unsigned band_hi(int unsigned i, int unsigned size);
    int unsigned e;
    e = band_lo(i + 1);
    return (e > size) ? size : e;
  endfunction

  function automatic bit [31:0] gain_scale(bit [15:0] s);
    longint unsigned p;
    p = longint'(s) * gain_q + 64'h8000;
    return p[47:16];
  endfunction

  function automatic bit [7:0] mean_byte(bit [43:0] sum, int unsigned cx, int unsigned cy);
    longint unsigned v;
    v = longint'(sum) / cx / cy;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic restart_frame();
    src_col = 0; src_row = 0; res_col = 0; res_row = 0;
    row_sum_a = '0; row_sum_b = '0; row_sum_c = '0;
    rband_lo = band_lo(0); rband_hi = band_hi(0, clip(src_h, 1, MaxWidth));
    cband_lo = band_lo(0); cband_hi = band_hi(0, clip(src_w, 1, MaxWidth));
  endtask

  task automatic shrink_pixel(in_word_t px);
    int unsigned w, h, rw, rh, col, cx, cy;
    bit [31:0] sa, sb, sc;
    bit in_rows, last_row, rlast, flast;
    bit [7:0] va, vb, vc, t;
    out_word_t o;
    if (px.frame_start) restart_frame();
    w = clip(src_w, 1, MaxWidth); h = clip(src_h, 1, MaxWidth);
    rw = clip(res_w, 0, 2048); rh = clip(res_h, 0, 2048);
    sa = gain_scale(px.sample_a); sb = gain_scale(px.sample_b); sc = gain_scale(px.sample_c);
    col = src_col;
    in_rows = res_row < rh && rband_lo <= src_row && src_row < rband_hi && col < MaxWidth;
    if (in_rows) begin
      if (src_row == rband_lo) begin
        col_sum_a[col] = sa; col_sum_b[col] = sb; col_sum_c[col] = sc;
      end else begin
        col_sum_a[col] += sa; col_sum_b[col] += sb; col_sum_c[col] += sc;
      end
    end
    last_row = in_rows && src_row + 1 == rband_hi;
    if (last_row && res_col < rw && cband_lo <= col && col < cband_hi) begin
      if (col == cband_lo) begin
        row_sum_a = col_sum_a[col]; row_sum_b = col_sum_b[col]; row_sum_c = col_sum_c[col];
      end else begin
        row_sum_a += col_sum_a[col]; row_sum_b += col_sum_b[col]; row_sum_c += col_sum_c[col];
      end
      if (col + 1 == cband_hi) begin
        cx = cband_hi - cband_lo;
        cy = rband_hi - rband_lo;
        va = mean_byte(row_sum_a, cx, cy);
        vb = mean_byte(row_sum_b, cx, cy);
        vc = mean_byte(row_sum_c, cx, cy);
        rlast = res_col + 1 >= rw || band_lo(res_col + 1) >= w;
        flast = rlast && (res_row + 1 >= rh || band_lo(res_row + 1) >= h);
        if (!colour_q) begin
          vb = va; vc = va;
        end
        if (swap_q) begin
          t = va; va = vc; vc = t;
        end
        o.out_byte0 = va; o.out_byte1 = vb; o.out_byte2 = vc;
        o.out_column = res_col[10:0]; o.out_row = res_row[10:0];
        o.row_last = rlast; o.frame_last = flast;
        shrunk_queue.push_back(o);
        res_col++;
        cband_lo = band_lo(res_col); cband_hi = band_hi(res_col, w);
      end
    end
    if (col + 1 >= w) begin
      src_col = 0; res_col = 0;
      cband_lo = band_lo(0); cband_hi = band_hi(0, w);
      if (src_row + 1 >= h) begin
        src_row = 0; res_row = 0;
        rband_lo = band_lo(0); rband_hi = band_hi(0, h);
      end else begin
        src_row++;
        if (last_row) begin
          res_row++;
          rband_lo = band_lo(res_row); rband_hi = band_hi(res_row, h);
        end
      end
    end else begin
      src_col++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // driver: hold a word until accepted, then wait out its gap and send the next
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_ready)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_data <= pixel_queue.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) shrink_pixel(in_data);
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(3) == 0) out_gap <= pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (shrunk_queue.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        e = shrunk_queue.pop_front();
        if (out_data.out_byte0 !== e.out_byte0 || out_data.out_byte1 !== e.out_byte1 ||
            out_data.out_byte2 !== e.out_byte2 || out_data.out_column !== e.out_column ||
            out_data.out_row !== e.out_row || out_data.row_last !== e.row_last ||
            out_data.frame_last !== e.frame_last) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SRC_W:  src_w = value & 13'h1FFF;
      REG_SRC_H:  src_h = value & 13'h1FFF;
      REG_RES_W:  res_w = value & 12'hFFF;
      REG_RES_H:  res_h = value & 12'hFFF;
      REG_STEP:   step_q = value & 16'hFFFF;
      REG_GAIN:   gain_q = value & 24'hFFFFFF;
      REG_COLOUR: colour_q = value[0];
      REG_SWAP:   swap_q = value[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || shrunk_queue.size() > 0) @(posedge clk);
    // let queued words with no result pass through to the back part
    repeat (300) @(posedge clk);
  endtask

  task automatic setup(int unsigned sw, int unsigned sh, int unsigned rw, int unsigned rh,
                       int unsigned st, int unsigned gn, bit cm, bit sw_ord);
    drain();
    reg_write(REG_SRC_W, sw); reg_write(REG_SRC_H, sh);
    reg_write(REG_RES_W, rw); reg_write(REG_RES_H, rh);
    reg_write(REG_STEP, st);  reg_write(REG_GAIN, gn);
    reg_write(REG_COLOUR, cm); reg_write(REG_SWAP, sw_ord);
    gaps_on = $urandom_range(3) != 0;
  endtask

  task automatic feed(int count, bit extremes);
    in_word_t px;
    for (int i = 0; i < count; i++) begin
      if (extremes) begin
        px.sample_a = (i % 2) ? 16'hFFFF : 16'h0000;
        px.sample_b = (i % 3) ? 16'h0000 : 16'hFFFF;
        px.sample_c = (i % 4 < 2) ? 16'hFFFF : 16'h0001;
      end else begin
        px.sample_a = $urandom; px.sample_b = $urandom; px.sample_c = $urandom;
      end
      px.frame_start = (i == 0) || ($urandom_range(99) == 0);
      pixel_queue.push_back(px);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    setup(4, 4, 2, 2, 512, 65536, 1, 0);            feed(16, 1);
    setup(4, 4, 2, 2, 512, 24'hFFFFFF, 0, 1);       feed(16, 0);
    setup(6, 5, 3, 2, 640, 0, 1, 1);                feed(60, 0);
    setup(7, 7, 3, 3, 600, 98304, 1, 0);            feed(100, 0);
    drain();                                        feed(100, 0);
    setup(5, 3, 0, 1, 512, 65536, 1, 0);            feed(30, 0);
    setup(300, 1, 2, 1, 65535, 40000, 1, 1);        feed(300, 0);
    setup(4096, 4096, 2048, 2048, 512, 65536, 0, 0); feed(200, 0);
    setup(1, 1, 1, 1, 512, 70000, 1, 1);            feed(12, 0);
    setup(9, 8, 4, 4, 512, 70000, 1, 0);            feed(166, 0);
    setup(8, 6, 5, 4, 700, 20000, 0, 1);            feed(150, 0);
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
